// ----- sv/rau_pkg.sv -----
package rau_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned ProdWidth = 2 * DataWidth;
   localparam int unsigned MagWidth  = ProdWidth + 1;
   localparam int unsigned CntWidth  = $clog2(MagWidth + 1);

   typedef enum logic [3:0] {
      CMD_MAKE = 4'd0,
      CMD_ADD  = 4'd1,
      CMD_SUB  = 4'd2,
      CMD_MUL  = 4'd3,
      CMD_DIV  = 4'd4,
      CMD_LT   = 4'd5,
      CMD_GT   = 4'd6,
      CMD_EQ   = 4'd7,
      CMD_NE   = 4'd8,
      CMD_LE   = 4'd9,
      CMD_GE   = 4'd10
   } cmd_type;

   typedef struct packed {
      logic [3:0]                  cmd;
      logic signed [DataWidth-1:0] a_num;
      logic signed [DataWidth-1:0] a_den;
      logic signed [DataWidth-1:0] b_num;
      logic signed [DataWidth-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] res_num;
      logic [DataWidth-2:0]        res_den;
      logic                        cmp_true;
      logic                        overflow;
   } rsp_type;

   // Sequencer commands to the datapath.
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic mul3;
      logic combine;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic finish;
   } dp_cmd_type;

   // Datapath status back to the sequencer.
   typedef struct packed {
      logic is_cmp;
      logic gcd_done;
      logic div_done;
   } dp_sts_type;

endpackage

// ----- sv/rau_if.sv -----
interface rau_req_if;
   logic              valid;
   logic              ready;
   rau_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rau_rsp_if;
   logic              valid;
   logic              ready;
   rau_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/rational_arithmetic_unit.sv -----
// Compares go from the combine state straight to the result; arithmetic and unused
// codes first run the binary gcd steps and then the two reducing divisions.
// One item is in flight at a time; the next is taken the cycle after the result beat
// leaves.
// Synchronous active-high reset returns the sequencer to idle with no result pending.
module rational_arithmetic_unit (
   input logic      clock,
   input logic      reset,
   rau_req_if.sink  req,
   rau_rsp_if.source rsp
);

   rau_pkg::dp_cmd_type dp_cmd;
   rau_pkg::dp_sts_type dp_sts;

   rau_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   rau_datapath u_datapath (
      .clock (clock),
      .req   (req.payload),
      .cmd   (dp_cmd),
      .sts   (dp_sts),
      .rsp   (rsp.payload)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input taken with result pending");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.cmp_true |-> rsp.payload.overflow == 1'b0)
      else $error("compare result flagged overflow");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.overflow |-> rsp.payload.res_den == '0)
      else $error("overflow with nonzero denominator");

endmodule

// ----- sv/rau_datapath.sv -----
module rau_datapath (
   input  logic                 clock,
   input  rau_pkg::req_type     req,
   input  rau_pkg::dp_cmd_type  cmd,
   output rau_pkg::dp_sts_type  sts,
   output rau_pkg::rsp_type     rsp
);

   localparam int unsigned W = rau_pkg::DataWidth;
   localparam int unsigned M = rau_pkg::MagWidth;

   rau_pkg::req_type op_ff;
   logic [M-1:0]   p0_ff, p1_ff, p2_ff;
   logic           s0_ff, s1_ff, s2_ff;
   logic [M-1:0]   nmag_ff, dmag_ff;
   logic           nneg_ff, dneg_ff;
   logic [M-1:0]   ga_ff, gb_ff;
   logic [rau_pkg::CntWidth-1:0] gk_ff;
   logic [M-1:0]   dvs_ff;
   logic [M-1:0]   quo_ff, rem_ff, dvd_ff;
   logic [M-1:0]   nq_ff;
   logic           second_ff;
   logic [rau_pkg::CntWidth-1:0] bit_ff;
   logic           cmp_ff;
   rau_pkg::rsp_type rsp_ff, rsp_in;
   logic           addsub;

   function automatic logic [W-1:0] absv(input logic signed [W-1:0] v);
      absv = v[W-1] ? W'(-v) : v;
   endfunction

   assign addsub = op_ff.cmd inside {rau_pkg::CMD_ADD, rau_pkg::CMD_SUB};

   // Multiplier operands for the three product steps (mul1, mul2, mul3).
   logic [W-1:0] ma, mb;
   logic         msign;
   logic [2*W-1:0] mprod;
   logic signed [W-1:0] mx, my;
   always_comb begin
      if (cmd.mul1) begin
         case (op_ff.cmd)
            rau_pkg::CMD_MUL: begin mx = op_ff.a_num; my = op_ff.b_num; end
            default: begin mx = op_ff.a_num; my = op_ff.b_den; end
         endcase
      end else if (cmd.mul3) begin
         mx = op_ff.a_den;
         my = op_ff.b_den;
      end else begin
         case (op_ff.cmd)
            rau_pkg::CMD_MUL: begin mx = op_ff.a_den; my = op_ff.b_den; end
            rau_pkg::CMD_DIV: begin mx = op_ff.a_den; my = op_ff.b_num; end
            default: begin mx = op_ff.b_num; my = op_ff.a_den; end
         endcase
      end
      ma = absv(mx);
      mb = absv(my);
      mprod = ma * mb;
      msign = (mx[W-1] ^ my[W-1]) && (mprod != '0);
   end

   // Signed-magnitude add for add and subtract.
   logic [M-1:0] sum_mag;
   logic         sum_neg, bneg;
   always_comb begin
      bneg = (op_ff.cmd == rau_pkg::CMD_SUB) ? (s2_ff ^ (p2_ff != '0)) : s2_ff;
      if (s0_ff == bneg) begin
         sum_mag = p0_ff + p2_ff;
         sum_neg = s0_ff;
      end else if (p0_ff >= p2_ff) begin
         sum_mag = p0_ff - p2_ff;
         sum_neg = s0_ff;
      end else begin
         sum_mag = p2_ff - p0_ff;
         sum_neg = bneg;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   // One restoring division step.
   logic [M:0]   trial;
   logic [M-1:0] rem_sh;
   always_comb begin
      rem_sh = {rem_ff[M-2:0], dvd_ff[M-1]};
      trial  = {1'b0, rem_sh} - {1'b0, dvs_ff};
   end

   // Signed cross products for compares (each fits 64 bits).
   logic signed [2*W:0] lhs, rhs;
   always_comb begin
      lhs = s0_ff ? -$signed({1'b0, p0_ff[2*W-1:0]}) : $signed({1'b0, p0_ff[2*W-1:0]});
      rhs = s1_ff ? -$signed({1'b0, p1_ff[2*W-1:0]}) : $signed({1'b0, p1_ff[2*W-1:0]});
   end

   logic          res_neg;
   logic [M-1:0]  lim_n;
   logic [M-1:0]  lim_d;
   always_comb begin
      res_neg = nneg_ff ^ dneg_ff;
      lim_d = M'({1'b0, {(W-1){1'b1}}});
      lim_n = res_neg ? lim_d + M'(1) : lim_d;
   end

   always_comb begin
      rsp_in = '0;
      if (sts.is_cmp) begin
         rsp_in.cmp_true = cmp_ff;
      end else if (op_ff.cmd > rau_pkg::CMD_GE) begin
         rsp_in = '0;
      end else if (nmag_ff == '0) begin
         rsp_in.res_den = (W-1)'(1);
      end else if (dmag_ff == '0) begin
         rsp_in.res_num = nneg_ff ? '1 : W'(1);
      end else if (nq_ff > lim_n || quo_ff > lim_d) begin
         rsp_in.overflow = 1'b1;
      end else begin
         rsp_in.res_num = res_neg ? W'(-nq_ff) : W'(nq_ff);
         rsp_in.res_den = (W-1)'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req;
      end
      if (cmd.mul1) begin
         if (op_ff.cmd == rau_pkg::CMD_MAKE) begin
            p0_ff <= M'(absv(op_ff.a_num));
            s0_ff <= op_ff.a_num[W-1];
         end else begin
            p0_ff <= M'(mprod);
            s0_ff <= msign;
         end
      end
      if (cmd.mul2) begin
         if (addsub) begin
            // Second cross product goes to p2; the denominator product follows.
            p2_ff <= M'(mprod);
            s2_ff <= msign;
         end else begin
            p1_ff <= (op_ff.cmd == rau_pkg::CMD_MAKE) ? M'(absv(op_ff.a_den)) : M'(mprod);
            s1_ff <= (op_ff.cmd == rau_pkg::CMD_MAKE) ? op_ff.a_den[W-1] : msign;
         end
      end
      if (cmd.mul3 && addsub) begin
         p1_ff <= M'(mprod);
         s1_ff <= msign;
      end
      if (cmd.combine) begin
         if (addsub) begin
            nmag_ff <= sum_mag;
            nneg_ff <= sum_neg;
         end else begin
            nmag_ff <= p0_ff;
            nneg_ff <= s0_ff;
         end
         dmag_ff <= p1_ff;
         dneg_ff <= s1_ff;
         ga_ff   <= addsub ? sum_mag : p0_ff;
         gb_ff   <= p1_ff;
         gk_ff   <= '0;
         case (op_ff.cmd)
            rau_pkg::CMD_LT: cmp_ff <= lhs < rhs;
            rau_pkg::CMD_GT: cmp_ff <= lhs > rhs;
            rau_pkg::CMD_LE: cmp_ff <= lhs <= rhs;
            rau_pkg::CMD_GE: cmp_ff <= lhs >= rhs;
            rau_pkg::CMD_EQ: cmp_ff <= op_ff.a_num == op_ff.b_num && op_ff.a_den == op_ff.b_den;
            rau_pkg::CMD_NE: cmp_ff <= op_ff.a_num != op_ff.b_num || op_ff.a_den != op_ff.b_den;
            default: cmp_ff <= 1'b0;
         endcase
      end
      // Binary gcd: shared factors of two go into the count, then an even value is halved
      // and two odd values are subtracted and halved until one side reaches zero.
      if (cmd.gcd_step) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff <= ga_ff >> 1;
            gb_ff <= gb_ff >> 1;
            gk_ff <= gk_ff + 1'b1;
         end else if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_ff <= (ga_ff - gb_ff) >> 1;
         end else begin
            gb_ff <= (gb_ff - ga_ff) >> 1;
         end
      end
      if (cmd.div_start) begin
         dvs_ff    <= (ga_ff | gb_ff) << gk_ff;
         dvd_ff    <= second_ff ? dmag_ff : nmag_ff;
         rem_ff    <= '0;
         quo_ff    <= '0;
         bit_ff    <= rau_pkg::CntWidth'(M);
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[M-2:0], 1'b0};
         if (!trial[M]) begin
            rem_ff <= trial[M-1:0];
            quo_ff <= {quo_ff[M-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[M-2:0], 1'b0};
         end
         bit_ff <= bit_ff - 1'b1;
         if (bit_ff == rau_pkg::CntWidth'(1)) begin
            second_ff <= ~second_ff;
            if (!second_ff) nq_ff <= trial[M] ? {quo_ff[M-2:0], 1'b0}
                                              : {quo_ff[M-2:0], 1'b1};
         end
      end
      if (cmd.load) second_ff <= 1'b0;
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   always_comb begin
      sts.is_cmp   = op_ff.cmd inside {[rau_pkg::CMD_LT:rau_pkg::CMD_GE]};
      sts.gcd_done = (ga_ff == '0) || (gb_ff == '0);
      sts.div_done = (bit_ff == rau_pkg::CntWidth'(1));
   end

   assign rsp = rsp_ff;

endmodule

// ----- sv/rau_control.sv -----
module rau_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rau_pkg::dp_sts_type  sts,
   output rau_pkg::dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_COMB, ST_GCD, ST_DSTART, ST_DIV,
      ST_DSTART2, ST_DIV2, ST_FIN, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin cmd.load = 1'b1; state_in = ST_MUL1; end
         ST_MUL1: begin cmd.mul1 = 1'b1; state_in = ST_MUL2; end
         ST_MUL2: begin cmd.mul2 = 1'b1; state_in = ST_MUL3; end
         ST_MUL3: begin cmd.mul3 = 1'b1; state_in = ST_COMB; end
         ST_COMB: begin
            cmd.combine = 1'b1;
            state_in = sts.is_cmp ? ST_FIN : ST_GCD;
         end
         ST_GCD: begin
            if (sts.gcd_done) state_in = ST_DSTART;
            else cmd.gcd_step = 1'b1;
         end
         ST_DSTART: begin cmd.div_start = 1'b1; state_in = ST_DIV; end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_DSTART2;
         end
         ST_DSTART2: begin cmd.div_start = 1'b1; state_in = ST_DIV2; end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin cmd.finish = 1'b1; state_in = ST_OUT; end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_in == ST_OUT);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- dv/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

   localparam logic [3:0] FirstUnusedCmd = 4'd11;
   localparam logic [3:0] LastUnusedCmd  = 4'd15;

   typedef struct {
      bit        neg;
      bit [63:0] mag;
   } signed_mag_type;

   logic clock;
   logic reset;

   rau_req_if req_if ();
   rau_rsp_if rsp_if ();

   rational_arithmetic_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   rau_pkg::rsp_type expected_fractions[$];
   int      error_count;
   int      items_sent;
   int      results_checked;
   int      overflow_seen;
   int      compare_true_seen;
   bit      sender_busy_mode;
   bit      receiver_busy_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Magnitude and sign arithmetic at double width, never wrapping.
   function automatic signed_mag_type to_sign_mag(longint v);
      signed_mag_type r;
      bit [63:0]   u;
      u     = v;
      r.neg = v < 0;
      r.mag = r.neg ? 64'd0 - u : u;
      return r;
   endfunction

   function automatic signed_mag_type product(longint x, longint y);
      signed_mag_type a, b, r;
      a     = to_sign_mag(x);
      b     = to_sign_mag(y);
      r.mag = a.mag * b.mag;
      r.neg = (a.neg != b.neg) && r.mag != 0;
      return r;
   endfunction

   function automatic signed_mag_type sum(signed_mag_type a, signed_mag_type b);
      signed_mag_type r;
      if (a.neg == b.neg) begin
         r.neg = a.neg;
         r.mag = a.mag + b.mag;
      end else if (a.mag >= b.mag) begin
         r.neg = a.neg;
         r.mag = a.mag - b.mag;
      end else begin
         r.neg = b.neg;
         r.mag = b.mag - a.mag;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic rau_pkg::rsp_type reduce_fraction(signed_mag_type n, signed_mag_type d);
      rau_pkg::rsp_type r;
      bit [63:0] x, y, t, nm, dm, half;
      bit        neg;
      r    = '0;
      half = 64'h8000_0000;
      if (n.mag == 0) begin
         r.res_den = 31'd1;
      end else if (d.mag == 0) begin
         r.res_num = n.neg ? -32'sd1 : 32'sd1;
      end else begin
         neg = n.neg != d.neg;
         x   = n.mag;
         y   = d.mag;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         nm = n.mag / x;
         dm = d.mag / x;
         if (nm > (neg ? half : half - 1) || dm > half - 1) begin
            r.overflow = 1'b1;
         end else begin
            r.res_num = neg ? 32'(64'd0 - nm) : nm[31:0];
            r.res_den = dm[30:0];
         end
      end
      return r;
   endfunction

   function automatic rau_pkg::rsp_type predict_fraction(rau_pkg::req_type q);
      rau_pkg::rsp_type r;
      signed_mag_type   t;
      longint      an, ad, bn, bd, lhs, rhs;
      r   = '0;
      an  = q.a_num;
      ad  = q.a_den;
      bn  = q.b_num;
      bd  = q.b_den;
      lhs = an * bd;
      rhs = bn * ad;
      case (q.cmd)
         rau_pkg::CMD_MAKE: r = reduce_fraction(to_sign_mag(an), to_sign_mag(ad));
         rau_pkg::CMD_ADD:
            r = reduce_fraction(sum(product(an, bd), product(bn, ad)), product(ad, bd));
         rau_pkg::CMD_SUB: begin
            t = product(bn, ad);
            if (t.mag != 0) t.neg = !t.neg;
            r = reduce_fraction(sum(product(an, bd), t), product(ad, bd));
         end
         rau_pkg::CMD_MUL:  r = reduce_fraction(product(an, bn), product(ad, bd));
         rau_pkg::CMD_DIV:  r = reduce_fraction(product(an, bd), product(ad, bn));
         rau_pkg::CMD_LT:   r.cmp_true = lhs < rhs;
         rau_pkg::CMD_GT:   r.cmp_true = lhs > rhs;
         rau_pkg::CMD_EQ:   r.cmp_true = an == bn && ad == bd;
         rau_pkg::CMD_NE:   r.cmp_true = an != bn || ad != bd;
         rau_pkg::CMD_LE:   r.cmp_true = lhs <= rhs;
         rau_pkg::CMD_GE:   r.cmp_true = lhs >= rhs;
         default:  r = '0;
      endcase
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      error_count++;
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
   endtask

   function automatic int pick_gap(bit busy);
      if (!busy) return 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 0;
         9:          return $urandom_range(15, 60);
         default:    return $urandom_range(1, 3);
      endcase
   endfunction

   // Result side: random back-pressure, with quiet stretches.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) receiver_busy_mode = ~receiver_busy_mode;
         if (reset) rsp_if.ready = 1'b0;
         else rsp_if.ready = receiver_busy_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
         if (receiver_busy_mode && $urandom_range(0, 40) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(10, 50)) @(negedge clock);
         end
      end
   end

   // Every result beat is checked against the oldest expectation.
   initial begin
      rau_pkg::rsp_type got, want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_fractions.size() == 0) begin
               report("unexpected result beat", 0, 0);
            end else begin
               want = expected_fractions.pop_front();
               results_checked++;
               if (want.overflow) overflow_seen++;
               if (want.cmp_true) compare_true_seen++;
               if (got.res_num !== want.res_num) report("res_num", got.res_num, want.res_num);
               if (got.res_den !== want.res_den) report("res_den", got.res_den, want.res_den);
               if (got.cmp_true !== want.cmp_true)
                  report("cmp_true", got.cmp_true, want.cmp_true);
               if (got.overflow !== want.overflow)
                  report("overflow", got.overflow, want.overflow);
            end
         end
      end
   end

   task automatic send_item(logic [3:0] cmd, int an, int ad, int bn, int bd);
      rau_pkg::req_type q;
      int      gap;
      q.cmd   = cmd;
      q.a_num = an;
      q.a_den = ad;
      q.b_num = bn;
      q.b_den = bd;
      gap     = pick_gap(sender_busy_mode);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload = q;
      req_if.valid   = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      expected_fractions.push_back(predict_fraction(q));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_if.valid = 1'b0;
      while (expected_fractions.size() != 0) @(negedge clock);
   endtask

   function automatic int random_operand();
      case ($urandom_range(0, 7))
         0:       return int'($urandom_range(0, 40)) - 20;
         1:       return 0;
         2:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         3:       return $urandom_range(0, 1) ? (1 <<< $urandom_range(0, 30))
                                              : -(1 <<< $urandom_range(0, 31));
         4, 5:    return int'($urandom_range(0, 65535)) - 32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_make();
      send_item(rau_pkg::CMD_MAKE, 6, -4, 0, 0);
      send_item(rau_pkg::CMD_MAKE, 0, -7, 1, 1);
      send_item(rau_pkg::CMD_MAKE, -5, 0, 1, 1);
      send_item(rau_pkg::CMD_MAKE, 32'sh8000_0000, 0, 1, 1);
      send_item(rau_pkg::CMD_MAKE, 32'sh8000_0000, 1, 1, 1);
      send_item(rau_pkg::CMD_MAKE, 32'sh8000_0000, -1, 1, 1);
      send_item(rau_pkg::CMD_MAKE, 32'sh7fff_ffff, 32'sh8000_0000, 1, 1);
   endtask

   task automatic test_arithmetic();
      send_item(rau_pkg::CMD_ADD, 1, 2, 1, 3);
      send_item(rau_pkg::CMD_ADD, 1, 32'sh7fff_ffff, 1, 32'sh7fff_fffe);
      send_item(rau_pkg::CMD_SUB, 3, 4, 3, 4);
      send_item(rau_pkg::CMD_SUB, 32'sh8000_0000, 1, 32'sh7fff_ffff, 1);
      send_item(rau_pkg::CMD_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
      send_item(rau_pkg::CMD_MUL, -6, 35, 14, -9);
      send_item(rau_pkg::CMD_DIV, 2, 3, 0, 5);
      send_item(rau_pkg::CMD_DIV, -2, 3, 4, -9);
   endtask

   task automatic test_compare();
      send_item(rau_pkg::CMD_LT, 1, 3, 1, 2);
      send_item(rau_pkg::CMD_GT, 32'sh8000_0000, 1, 32'sh7fff_ffff, 1);
      send_item(rau_pkg::CMD_EQ, 1, 2, 2, 4);
      send_item(rau_pkg::CMD_EQ, -3, 7, -3, 7);
      send_item(rau_pkg::CMD_NE, 1, 2, 2, 4);
      send_item(rau_pkg::CMD_LE, 2, 4, 1, 2);
      send_item(rau_pkg::CMD_GE, 1, -2, 1, 2);
   endtask

   task automatic test_unused_codes();
      for (logic [4:0] c = FirstUnusedCmd; c <= LastUnusedCmd; c++)
         send_item(c[3:0], 5, 7, -3, 2);
   endtask

   task automatic test_random(int count);
      logic [3:0] cmd;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 31) == 0) sender_busy_mode = ~sender_busy_mode;
         if ($urandom_range(0, 19) == 0)
            cmd = 4'($urandom_range(FirstUnusedCmd, LastUnusedCmd));
         else cmd = 4'($urandom_range(rau_pkg::CMD_MAKE, rau_pkg::CMD_GE));
         send_item(cmd, random_operand(), random_operand(), random_operand(), random_operand());
         if (i == count / 2) wait_for_results();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.payload     = '0;
      sender_busy_mode   = 1'b1;
      receiver_busy_mode = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_make();
      test_arithmetic();
      wait_for_results();
      test_compare();
      test_unused_codes();
      test_random(400);

      wait_for_results();
      repeat (300) @(posedge clock);
      $display("Covered %0d requests over all commands, unused codes and edge operands;",
               items_sent);
      $display("%0d results checked, %0d overflows, %0d true compares, %0d errors.",
               results_checked, overflow_seen, compare_true_seen, error_count);
      if (error_count == 0 && expected_fractions.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
